FILE: hw/rtl/psdc_pkg.sv
// Shared constants, types and codes for the PID servo duty controller.
// Used by every module under hw/rtl; no dependencies of its own.
package psdc_pkg;

  // Field widths and fixed-point formats
  localparam int POS_W          = 12;
  localparam int GAIN_W         = 16;
  localparam int GAIN_FRAC_BITS = 14;
  localparam int INTEG_W        = 24;
  localparam int SAMPLE_RATE_HZ = 20;
  localparam int RATE_SQ        = SAMPLE_RATE_HZ * SAMPLE_RATE_HZ;

  localparam int DRV_W      = 16;
  localparam int CEIL_W     = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int PULSE_W    = 11;

  localparam int PULSE_MIN_US  = 1000;
  localparam int PULSE_SPAN_US = 1000;

  // Datapath widths
  localparam int ERR_W    = POS_W + 1;
  localparam int ISUM_W   = INTEG_W + 1;
  localparam int DTERM_W  = ERR_W + $clog2(RATE_SQ + 1);
  localparam int TERM_W   = (INTEG_W > DTERM_W) ? INTEG_W : DTERM_W;
  localparam int SEL_W    = TERM_W + 2;
  localparam int NUM_W    = SEL_W + GAIN_W;
  localparam int DVD_W    = NUM_W - 1 - GAIN_FRAC_BITS;
  localparam int REM_W    = $clog2(SAMPLE_RATE_HZ + 1);
  localparam int TRIAL_W  = REM_W + 1;
  localparam int RAW_W    = DVD_W + 1;
  localparam int SPAN_W   = DRV_W;
  localparam int SPAN_FULL_W = DRV_W + 1;
  localparam int QUO_W    = $clog2(PULSE_SPAN_US + 1);
  localparam int PROD_W   = SPAN_W + QUO_W;

  localparam int MAC_CNT_W  = $clog2(GAIN_W);
  localparam int DIV_CNT_W  = $clog2(DVD_W);
  localparam int PDIV_CNT_W = $clog2(QUO_W);

  // Register reset values
  localparam logic [GAIN_W-1:0]        PROP_GAIN_RST     = GAIN_W'(15565);
  localparam logic [GAIN_W-1:0]        DERIV_GAIN_RST    = GAIN_W'(4915);
  localparam logic [GAIN_W-1:0]        INTEG_GAIN_RST    = GAIN_W'(328);
  localparam logic signed [DRV_W-1:0]  DRIVE_FLOOR_RST   = -DRV_W'(2000);
  localparam logic [CEIL_W-1:0]        DRIVE_CEILING_RST = CEIL_W'(2000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN,
    CFG_DERIV_GAIN,
    CFG_INTEG_GAIN,
    CFG_DRIVE_FLOOR,
    CFG_DRIVE_CEILING
  } psdc_cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DIV,
    ST_CLAMP,
    ST_MAP,
    ST_PULSE,
    ST_DONE
  } psdc_state_t;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] kd;
    logic [GAIN_W-1:0] ki;
  } psdc_gains_t;

  typedef struct packed {
    logic signed [TERM_W-1:0] a1;  // rate * err
    logic signed [TERM_W-1:0] a2;  // rate^2 * dpos
    logic signed [TERM_W-1:0] a3;  // error integral
  } psdc_terms_t;

endpackage

FILE: hw/rtl/psdc_mac.sv
// Bit-serial multiply-accumulate: sum of three gain-times-term products.
// One gain bit per cycle, MSB first. Depends on psdc_pkg.
module psdc_mac
  import psdc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  psdc_gains_t             gains,
  input  psdc_terms_t             terms,
  output logic                    done,
  output logic signed [NUM_W-1:0] num
);

  psdc_gains_t              gains_r, gains_nxt;
  psdc_terms_t              terms_r;
  logic signed [NUM_W-1:0]  acc_r, acc_nxt;
  logic [MAC_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                     active_r, active_nxt;
  logic                     done_r, done_nxt;
  logic signed [SEL_W-1:0]  sel;

  // Partial sum of the terms whose gain bit is set this cycle
  always_comb begin
    sel = '0;
    if (gains_r.kp[GAIN_W-1]) sel = sel + SEL_W'(terms_r.a1);
    if (gains_r.kd[GAIN_W-1]) sel = sel + SEL_W'(terms_r.a2);
    if (gains_r.ki[GAIN_W-1]) sel = sel + SEL_W'(terms_r.a3);
  end

  always_comb begin
    gains_nxt  = gains_r;
    acc_nxt    = acc_r;
    cnt_nxt    = cnt_r;
    active_nxt = active_r;
    done_nxt   = 1'b0;
    if (start) begin
      gains_nxt  = gains;
      acc_nxt    = '0;
      cnt_nxt    = '0;
      active_nxt = 1'b1;
    end else if (active_r) begin
      gains_nxt.kp = {gains_r.kp[GAIN_W-2:0], 1'b0};
      gains_nxt.kd = {gains_r.kd[GAIN_W-2:0], 1'b0};
      gains_nxt.ki = {gains_r.ki[GAIN_W-2:0], 1'b0};
      acc_nxt      = {acc_r[NUM_W-2:0], 1'b0} + NUM_W'(sel);
      cnt_nxt      = cnt_r + 1'b1;
      if (cnt_r == MAC_CNT_W'(GAIN_W - 1)) begin
        active_nxt = 1'b0;
        done_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      active_r <= active_nxt;
      done_r   <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gains_r <= gains_nxt;
    acc_r   <= acc_nxt;
    cnt_r   <= cnt_nxt;
    if (start) begin
      terms_r <= terms;
    end
  end

  assign done = done_r;
  assign num  = acc_r;

endmodule

FILE: hw/rtl/psdc_cdiv.sv
// Bit-serial divide of the accumulated numerator by rate * 2^frac,
// truncated toward zero and negated. Depends on psdc_pkg.
module psdc_cdiv
  import psdc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  output logic                    done,
  output logic signed [RAW_W-1:0] raw
);

  logic [NUM_W-1:0]        mag;
  logic [DVD_W-1:0]        dvd_r, dvd_nxt;
  logic [REM_W-1:0]        rem_r, rem_nxt;
  logic                    neg_r, neg_nxt;
  logic [DIV_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                    active_r, active_nxt;
  logic                    done_r, done_nxt;
  logic [TRIAL_W-1:0]      trial;
  logic                    fits;
  logic signed [RAW_W-1:0] quo;

  assign mag   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign fits  = (trial >= TRIAL_W'(SAMPLE_RATE_HZ));

  // Quotient bits shift into the dividend register from the bottom
  always_comb begin
    dvd_nxt    = dvd_r;
    rem_nxt    = rem_r;
    neg_nxt    = neg_r;
    cnt_nxt    = cnt_r;
    active_nxt = active_r;
    done_nxt   = 1'b0;
    if (start) begin
      dvd_nxt    = mag[NUM_W-2:GAIN_FRAC_BITS];
      rem_nxt    = '0;
      neg_nxt    = num[NUM_W-1];
      cnt_nxt    = '0;
      active_nxt = 1'b1;
    end else if (active_r) begin
      rem_nxt = fits ? REM_W'(trial - TRIAL_W'(SAMPLE_RATE_HZ)) : trial[REM_W-1:0];
      dvd_nxt = {dvd_r[DVD_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DVD_W - 1)) begin
        active_nxt = 1'b0;
        done_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      active_r <= active_nxt;
      done_r   <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
  end

  // Drive is the negated quotient
  assign quo  = $signed({1'b0, dvd_r});
  assign raw  = neg_r ? quo : -quo;
  assign done = done_r;

endmodule

FILE: hw/rtl/psdc_pdiv.sv
// Restoring divider for the pulse map: floor(off * span_us / span).
// One quotient bit per cycle, MSB first. Depends on psdc_pkg.
module psdc_pdiv
  import psdc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SPAN_W-1:0] off,
  input  logic [SPAN_W-1:0] span,
  output logic              done,
  output logic [QUO_W-1:0]  quo
);

  logic [PROD_W-1:0]     rem_r, rem_nxt;
  logic [PROD_W-1:0]     dsr_r, dsr_nxt;
  logic [QUO_W-1:0]      quo_r, quo_nxt;
  logic [PDIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  active_r, active_nxt;
  logic                  done_r, done_nxt;
  logic                  ge;

  assign ge = (rem_r >= dsr_r);

  // off never exceeds span, so the quotient fits QUO_W bits
  always_comb begin
    rem_nxt    = rem_r;
    dsr_nxt    = dsr_r;
    quo_nxt    = quo_r;
    cnt_nxt    = cnt_r;
    active_nxt = active_r;
    done_nxt   = 1'b0;
    if (start) begin
      rem_nxt    = PROD_W'(off) * PROD_W'(PULSE_SPAN_US);
      dsr_nxt    = PROD_W'(span) << (QUO_W - 1);
      quo_nxt    = '0;
      cnt_nxt    = '0;
      active_nxt = 1'b1;
    end else if (active_r) begin
      if (ge) begin
        rem_nxt = rem_r - dsr_r;
      end
      dsr_nxt = dsr_r >> 1;
      quo_nxt = {quo_r[QUO_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == PDIV_CNT_W'(QUO_W - 1)) begin
        active_nxt = 1'b0;
        done_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      active_r <= active_nxt;
      done_r   <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

FILE: hw/rtl/pid_servo_duty_controller_core.sv
// PID servo duty controller, top level; uses psdc_pkg, psdc_mac, psdc_cdiv and
// psdc_pdiv. Each input transfer is one control tick: error, derivative and a
// saturating error integral are formed on transfer, then the drive is built
// by a bit-serial multiply-accumulate (one gain bit per cycle), a bit-serial
// divide by the sample rate, a clamp, and a 10-step restoring divide that
// maps the drive onto a 1000..2000 us pulse (skipped, giving 1000 us, when the
// span is not positive). The next input is taken only once the previous result
// sits in the output register, so a new tick waits while the last one is still
// in the serial multiply, the serial divides or the clamp. The output register
// holds a result until it is taken while the next tick is already in progress.
// Configuration writes are registered and must only occur while no tick is in
// flight.
module pid_servo_duty_controller_core
  import psdc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [POS_W-1:0]        in_measured_position,
  input  logic [POS_W-1:0]        in_target_position,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [PULSE_W-1:0]      out_pulse_width_us,
  output logic signed [DRV_W-1:0] out_drive_value,
  output logic                    out_drive_clamped,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  // Configuration registers
  logic [GAIN_W-1:0]        prop_gain_r, deriv_gain_r, integ_gain_r;
  logic signed [DRV_W-1:0]  drive_floor_r;
  logic [CEIL_W-1:0]        drive_ceiling_r;

  // Controller state
  logic [POS_W-1:0]          last_pos_r;
  logic signed [INTEG_W-1:0] integ_r, integ_sat;

  psdc_state_t state_r, state_nxt;

  logic in_fire, div_start, clamp_en, pdiv_start, out_load, out_free;
  logic mac_done, div_done, pdiv_done;

  logic signed [ERR_W-1:0]   err, dpos;
  logic signed [ISUM_W-1:0]  isum;
  psdc_gains_t               gains;
  psdc_terms_t               terms;
  logic signed [NUM_W-1:0]   num;
  logic signed [RAW_W-1:0]   raw;

  logic signed [RAW_W-1:0]   floor_x, ceil_x, d1, d2;
  logic signed [SPAN_FULL_W-1:0] span_full, off_full;

  logic signed [DRV_W-1:0]   drive_r, floor_snap_r;
  logic                      clamped_r, span_ok_r;
  logic [SPAN_W-1:0]         span_r;
  logic [QUO_W-1:0]          quo;
  logic [PULSE_W-1:0]        pulse;

  logic                      out_valid_r;
  logic [PULSE_W-1:0]        out_pulse_r;
  logic signed [DRV_W-1:0]   out_drive_r;
  logic                      out_clamped_r;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r     <= PROP_GAIN_RST;
      deriv_gain_r    <= DERIV_GAIN_RST;
      integ_gain_r    <= INTEG_GAIN_RST;
      drive_floor_r   <= DRIVE_FLOOR_RST;
      drive_ceiling_r <= DRIVE_CEILING_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PROP_GAIN:     prop_gain_r     <= cfg_data[GAIN_W-1:0];
        CFG_DERIV_GAIN:    deriv_gain_r    <= cfg_data[GAIN_W-1:0];
        CFG_INTEG_GAIN:    integ_gain_r    <= cfg_data[GAIN_W-1:0];
        CFG_DRIVE_FLOOR:   drive_floor_r   <= $signed(cfg_data[DRV_W-1:0]);
        CFG_DRIVE_CEILING: drive_ceiling_r <= cfg_data[CEIL_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- tick front end
  assign in_fire = in_valid && in_ready;
  assign err     = $signed({1'b0, in_measured_position}) - $signed({1'b0, in_target_position});
  assign dpos    = $signed({1'b0, in_measured_position}) - $signed({1'b0, last_pos_r});
  assign isum    = ISUM_W'(integ_r) + ISUM_W'(err);

  // Saturate the integral to its signed range
  always_comb begin
    if (isum[ISUM_W-1] != isum[INTEG_W-1]) begin
      integ_sat = isum[ISUM_W-1] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      integ_sat = isum[INTEG_W-1:0];
    end
  end

  assign gains.kp = prop_gain_r;
  assign gains.kd = deriv_gain_r;
  assign gains.ki = integ_gain_r;
  assign terms.a1 = TERM_W'(err) * TERM_W'(SAMPLE_RATE_HZ);
  assign terms.a2 = TERM_W'(dpos) * TERM_W'(RATE_SQ);
  assign terms.a3 = TERM_W'(integ_sat);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pos_r <= '0;
      integ_r    <= '0;
    end else if (in_fire) begin
      last_pos_r <= in_measured_position;
      integ_r    <= integ_sat;
    end
  end

  // -------------------------------------------------------- serial datapath
  psdc_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_fire),
    .gains (gains),
    .terms (terms),
    .done  (mac_done),
    .num   (num)
  );

  psdc_cdiv u_cdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num),
    .done  (div_done),
    .raw   (raw)
  );

  // Floor clamp first, ceiling clamp last
  assign floor_x = RAW_W'(drive_floor_r);
  assign ceil_x  = RAW_W'($signed({1'b0, drive_ceiling_r}));
  assign d1      = (raw < floor_x) ? floor_x : raw;
  assign d2      = (d1 > ceil_x) ? ceil_x : d1;
  assign span_full = SPAN_FULL_W'($signed({1'b0, drive_ceiling_r}))
                   - SPAN_FULL_W'(drive_floor_r);

  // Snapshot the floor with the drive so the pulse map sees one consistent pair
  always_ff @(posedge clk) begin
    if (clamp_en) begin
      drive_r      <= d2[DRV_W-1:0];
      clamped_r    <= (d2 != raw);
      span_ok_r    <= !span_full[SPAN_FULL_W-1] && (span_full != '0);
      span_r       <= span_full[SPAN_W-1:0];
      floor_snap_r <= drive_floor_r;
    end
  end

  assign off_full = SPAN_FULL_W'(drive_r) - SPAN_FULL_W'(floor_snap_r);

  psdc_pdiv u_pdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (pdiv_start),
    .off   (off_full[SPAN_W-1:0]),
    .span  (span_r),
    .done  (pdiv_done),
    .quo   (quo)
  );

  assign pulse = span_ok_r ? PULSE_W'(PULSE_MIN_US) + PULSE_W'(quo) : PULSE_W'(PULSE_MIN_US);

  // ------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_MAC;
      ST_MAC:   if (mac_done) state_nxt = ST_DIV;
      ST_DIV:   if (div_done) state_nxt = ST_CLAMP;
      ST_CLAMP: state_nxt = ST_MAP;
      ST_MAP:   state_nxt = span_ok_r ? ST_PULSE : ST_DONE;
      ST_PULSE: if (pdiv_done) state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    div_start  = 1'b0;
    clamp_en   = 1'b0;
    pdiv_start = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      ST_IDLE:  in_ready   = 1'b1;
      ST_MAC:   div_start  = mac_done;
      ST_DIV:   ;
      ST_CLAMP: clamp_en   = 1'b1;
      ST_MAP:   pdiv_start = span_ok_r;
      ST_PULSE: ;
      ST_DONE:  out_load   = out_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // --------------------------------------------------------- output register
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pulse_r   <= pulse;
      out_drive_r   <= drive_r;
      out_clamped_r <= clamped_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pulse_width_us = out_pulse_r;
  assign out_drive_value    = out_drive_r;
  assign out_drive_clamped  = out_clamped_r;

  // ------------------------------------------------------------- assertions
  a_fire_starts_mac: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_MAC)
    else $error("input transfer did not start the multiply");

  a_mac_done_in_mac: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> state_r == ST_MAC)
    else $error("multiply finished outside its state");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divide finished outside its state");

  a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_pulse_r >= PULSE_W'(PULSE_MIN_US)) &&
                    (out_pulse_r <= PULSE_W'(PULSE_MIN_US + PULSE_SPAN_US)))
    else $error("pulse width out of range");

endmodule
